>>> rtl/assert_macros.svh
// assertion macros used by the checker file pngcrc_chk.sv
// expects signals named clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication, off while reset is held
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

>>> rtl/pngcrc_pkg.sv
// types, codes and crc-32 helpers for the png chunk framer
// no dependencies
`default_nettype none

package pngcrc_pkg;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES  = 32'hFFFFFFFF;
  localparam int          BURST_MAX = 12;
  localparam int          CNT_W     = $clog2(BURST_MAX + 1);

  localparam logic REQ_HDR  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_CRC  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  // accepted item waiting for the burst register
  typedef struct packed {
    logic        req;
    logic [31:0] tag;
    logic [30:0] len;
    logic [7:0]  db;
    logic [31:0] pre;   // crc after the first two tag bytes
  } hold_t;

  // bytewise table entry, eight shift steps
  function automatic logic [31:0] crc_tab(input logic [7:0] b);
    logic [31:0] c;
    c = {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
    return (c >> 8) ^ crc_tab(c[7:0] ^ b);
  endfunction

endpackage

`default_nettype wire

>>> rtl/png_chunk_crc_framer_core.sv
// png chunk framer: length, type, payload and crc-32 as a byte stream
// depends on pngcrc_pkg
//
// in channel: one item per handshake. in_tuser = 0 is a chunk header
// (tag and length), in_tuser = 1 is one payload byte of the open chunk.
// out channel: one framed byte per handshake, out_tuser gives its kind
// (length/type, data, crc, error), out_tlast marks the final byte that
// an input item causes.
// an item waits in the hold register, then its whole burst of 1, 5, 8
// or 12 bytes is loaded into the burst shift register, whose entry 0 is
// the shown byte. it drains one byte per cycle while out_tready is high,
// so payload items that do not close the chunk likewise run at one item
// per cycle, and a header gives 8 bytes (12 with zero length). the next
// burst loads in the cycle its predecessor's last byte is taken.
// each crc path is at most two table folds deep: two tag bytes before
// the hold register, two after it, or one payload byte.
// reset (synchronous, rst_n low) empties both stages, closes any chunk
// and sets the crc to all ones. when the receiver stalls, the shown byte
// holds, the hold register fills and then in_tready drops.
`default_nettype none

module png_chunk_crc_framer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // chunk_tag[31:0], chunk_length[62:32], data_byte[70:63]
  input  wire logic        in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // out_byte
  output logic [1:0]       out_tuser,  // out_kind
  output logic             out_tlast   // last_of_run
);

  pngcrc_pkg::hold_t        hold_r;
  logic                     hold_v_r;
  logic [7:0]               byte_r [pngcrc_pkg::BURST_MAX];
  pngcrc_pkg::kind_t        kind_r [pngcrc_pkg::BURST_MAX];
  logic [pngcrc_pkg::CNT_W-1:0] cnt_r;
  logic [31:0]              crc_r;
  logic [30:0]              left_r;
  logic                     open_r;

  logic [7:0]               ld_byte [pngcrc_pkg::BURST_MAX];
  pngcrc_pkg::kind_t        ld_kind [pngcrc_pkg::BURST_MAX];
  logic [pngcrc_pkg::CNT_W-1:0] ld_cnt;
  logic [31:0]              crc_nxt;
  logic [30:0]              left_nxt;
  logic                     open_nxt;

  logic                     in_fire;
  logic                     out_fire;
  logic                     load_fire;
  logic [31:0]              pre_crc;
  logic [31:0]              crc_h;
  logic [31:0]              crc_d;
  logic [30:0]              left_dec;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = byte_r[0];
  assign out_tuser  = kind_r[0];
  assign out_tlast  = (cnt_r == pngcrc_pkg::CNT_W'(1));

  assign out_fire  = out_tvalid && out_tready;
  assign load_fire = hold_v_r && ((cnt_r == '0) || (out_tlast && out_tready));
  assign in_tready = !hold_v_r || load_fire;
  assign in_fire   = in_tvalid && in_tready;

  // first half of the tag crc, before the hold register
  assign pre_crc = pngcrc_pkg::crc_fold(
                     pngcrc_pkg::crc_fold(pngcrc_pkg::CRC_ONES, in_tdata[31:24]),
                     in_tdata[23:16]);

  assign crc_h    = pngcrc_pkg::crc_fold(pngcrc_pkg::crc_fold(hold_r.pre, hold_r.tag[15:8]),
                                         hold_r.tag[7:0]);
  assign crc_d    = pngcrc_pkg::crc_fold(crc_r, hold_r.db);
  assign left_dec = left_r - 31'd1;

  always_comb begin
    for (int i = 0; i < pngcrc_pkg::BURST_MAX; i++) begin
      ld_byte[i] = 8'h00;
      ld_kind[i] = pngcrc_pkg::KIND_HDR;
    end
    ld_cnt   = '0;
    crc_nxt  = crc_r;
    left_nxt = left_r;
    open_nxt = open_r;
    if (hold_r.req == pngcrc_pkg::REQ_HDR) begin
      ld_byte[0] = {1'b0, hold_r.len[30:24]};
      ld_byte[1] = hold_r.len[23:16];
      ld_byte[2] = hold_r.len[15:8];
      ld_byte[3] = hold_r.len[7:0];
      ld_byte[4] = hold_r.tag[31:24];
      ld_byte[5] = hold_r.tag[23:16];
      ld_byte[6] = hold_r.tag[15:8];
      ld_byte[7] = hold_r.tag[7:0];
      crc_nxt    = crc_h;
      if (hold_r.len == '0) begin
        ld_byte[8]  = ~crc_h[31:24];
        ld_byte[9]  = ~crc_h[23:16];
        ld_byte[10] = ~crc_h[15:8];
        ld_byte[11] = ~crc_h[7:0];
        for (int i = 8; i < 12; i++) begin
          ld_kind[i] = pngcrc_pkg::KIND_CRC;
        end
        ld_cnt   = pngcrc_pkg::CNT_W'(12);
        open_nxt = 1'b0;
        left_nxt = '0;
      end else begin
        ld_cnt   = pngcrc_pkg::CNT_W'(8);
        open_nxt = 1'b1;
        left_nxt = hold_r.len;
      end
    end else if (!open_r) begin
      ld_byte[0] = hold_r.db;
      ld_kind[0] = pngcrc_pkg::KIND_ERR;
      ld_cnt     = pngcrc_pkg::CNT_W'(1);
    end else begin
      ld_byte[0] = hold_r.db;
      ld_kind[0] = pngcrc_pkg::KIND_DATA;
      crc_nxt    = crc_d;
      left_nxt   = left_dec;
      if (left_dec == '0) begin
        ld_byte[1] = ~crc_d[31:24];
        ld_byte[2] = ~crc_d[23:16];
        ld_byte[3] = ~crc_d[15:8];
        ld_byte[4] = ~crc_d[7:0];
        for (int i = 1; i < 5; i++) begin
          ld_kind[i] = pngcrc_pkg::KIND_CRC;
        end
        ld_cnt   = pngcrc_pkg::CNT_W'(5);
        open_nxt = 1'b0;
      end else begin
        ld_cnt = pngcrc_pkg::CNT_W'(1);
      end
    end
  end

  // hold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_fire) begin
      hold_v_r <= 1'b1;
    end else if (load_fire) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_r.req <= in_tuser;
      hold_r.tag <= in_tdata[31:0];
      hold_r.len <= in_tdata[62:32];
      hold_r.db  <= in_tdata[70:63];
      hold_r.pre <= pre_crc;
    end
  end

  // chunk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= pngcrc_pkg::CRC_ONES;
      left_r <= '0;
      open_r <= 1'b0;
    end else if (load_fire) begin
      crc_r  <= crc_nxt;
      left_r <= left_nxt;
      open_r <= open_nxt;
    end
  end

  // burst shift register, entry 0 is on the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load_fire) begin
      cnt_r <= ld_cnt;
    end else if (out_fire) begin
      cnt_r <= cnt_r - pngcrc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      for (int i = 0; i < pngcrc_pkg::BURST_MAX; i++) begin
        byte_r[i] <= ld_byte[i];
        kind_r[i] <= ld_kind[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < pngcrc_pkg::BURST_MAX - 1; i++) begin
        byte_r[i] <= byte_r[i+1];
        kind_r[i] <= kind_r[i+1];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/pngcrc_chk.sv
// port-level checks for png_chunk_crc_framer_core, bound to the top level
// depends on pngcrc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pngcrc_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  logic out_fire;
  assign out_fire = out_tvalid && out_tready;

  // a stalled byte holds
  `AST_NXT(a_out_hold, out_tvalid && !out_tready,
           out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // an error stands alone
  `AST_IMP(a_err_last, out_tvalid && out_tuser == pngcrc_pkg::KIND_ERR, out_tlast)

  // crc bytes come as one unbroken group
  `AST_NXT(a_crc_run, out_fire && out_tuser == pngcrc_pkg::KIND_CRC && !out_tlast,
           out_tvalid && out_tuser == pngcrc_pkg::KIND_CRC)

  // a data byte that is not last closes the chunk, its crc follows at once
  `AST_NXT(a_data_crc, out_fire && out_tuser == pngcrc_pkg::KIND_DATA && !out_tlast,
           out_tvalid && out_tuser == pngcrc_pkg::KIND_CRC)

  // input only backs up behind a waiting burst
  `AST_IMP(a_in_stall, in_tvalid && !in_tready, out_tvalid)

endmodule

bind png_chunk_crc_framer_core pngcrc_chk u_pngcrc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
